FILE: rtl/core/fax_run_length_code_lookup_assert.svh
// ----------------------------------------------------------------------------
// Fax run-length code lookup: assertion macros
// Property macros for the lookup core; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef FAX_RUN_LENGTH_CODE_LOOKUP_ASSERT_SVH
`define FAX_RUN_LENGTH_CODE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FAX_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fax lookup: same-cycle check failed");
// next-cycle implication
`define FAX_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fax lookup: next-cycle check failed");
`else
`define FAX_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FAX_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/core/fax_rlc_pkg.sv
// ----------------------------------------------------------------------------
// Fax run-length code package
// Commands, widths and the fixed T.4/T.6 code table shared by the lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package fax_rlc_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_DEC_WHITE = 3'd0,
        CMD_DEC_BLACK = 3'd1,
        CMD_DEC_MODE  = 3'd2,
        CMD_ENC_WHITE = 3'd3,
        CMD_ENC_BLACK = 3'd4,
        CMD_ENC_MODE  = 3'd5
    } cmd_t;

    localparam int WINDOW_BITS   = 13;
    localparam int MODE_BITS     = 7;
    localparam int LEN_W         = 4;
    localparam int CW_BITS_W     = 8;
    localparam int RUN_W         = 12;
    localparam int MODE_W        = 4;
    localparam int RUN_LEN_W     = 16;
    localparam int RUN_IDX_W     = 7;
    localparam int ADDR_W        = 8;

    localparam int TERM_COUNT    = 64;
    localparam int COLOUR_COUNT  = 91;
    localparam int SHARED_COUNT  = 13;
    localparam int MAKEUP_COUNT  = 40;
    localparam int MODE_COUNT    = 9;

    localparam int WHITE_BASE    = 0;
    localparam int BLACK_BASE    = COLOUR_COUNT;
    localparam int SHARED_BASE   = 2 * COLOUR_COUNT;
    localparam int MODE_BASE     = SHARED_BASE + SHARED_COUNT;
    localparam int ROM_DEPTH     = MODE_BASE + MODE_COUNT;

    // one code word: bits right-aligned in len
    typedef struct packed {
        logic [CW_BITS_W-1:0] bits;
        logic [LEN_W-1:0]     len;
    } cw_t;

    // lookup request handed from the index logic to the output stage
    typedef struct packed {
        logic                 hit;
        logic [ADDR_W-1:0]    addr;
        logic [RUN_W-1:0]     run_value;
        logic                 is_makeup;
        logic [MODE_W-1:0]    mode;
    } lookup_req_t;

    // white terminating/make-up, black terminating/make-up, shared make-up, modes
    localparam cw_t CODE_TABLE [ROM_DEPTH] = '{
        '{8'h35,4'd8},'{8'h07,4'd6},'{8'h07,4'd4},'{8'h08,4'd4},
        '{8'h0B,4'd4},'{8'h0C,4'd4},'{8'h0E,4'd4},'{8'h0F,4'd4},
        '{8'h13,4'd5},'{8'h14,4'd5},'{8'h07,4'd5},'{8'h08,4'd5},
        '{8'h08,4'd6},'{8'h03,4'd6},'{8'h34,4'd6},'{8'h35,4'd6},
        '{8'h2A,4'd6},'{8'h2B,4'd6},'{8'h27,4'd7},'{8'h0C,4'd7},
        '{8'h08,4'd7},'{8'h17,4'd7},'{8'h03,4'd7},'{8'h04,4'd7},
        '{8'h28,4'd7},'{8'h2B,4'd7},'{8'h13,4'd7},'{8'h24,4'd7},
        '{8'h18,4'd7},'{8'h02,4'd8},'{8'h03,4'd8},'{8'h1A,4'd8},
        '{8'h1B,4'd8},'{8'h12,4'd8},'{8'h13,4'd8},'{8'h14,4'd8},
        '{8'h15,4'd8},'{8'h16,4'd8},'{8'h17,4'd8},'{8'h28,4'd8},
        '{8'h29,4'd8},'{8'h2A,4'd8},'{8'h2B,4'd8},'{8'h2C,4'd8},
        '{8'h2D,4'd8},'{8'h04,4'd8},'{8'h05,4'd8},'{8'h0A,4'd8},
        '{8'h0B,4'd8},'{8'h52,4'd8},'{8'h53,4'd8},'{8'h54,4'd8},
        '{8'h55,4'd8},'{8'h24,4'd8},'{8'h25,4'd8},'{8'h58,4'd8},
        '{8'h59,4'd8},'{8'h5A,4'd8},'{8'h5B,4'd8},'{8'h4A,4'd8},
        '{8'h4B,4'd8},'{8'h32,4'd8},'{8'h33,4'd8},'{8'h34,4'd8},
        '{8'h1B,4'd5},'{8'h12,4'd5},'{8'h17,4'd6},'{8'h37,4'd7},
        '{8'h36,4'd8},'{8'h37,4'd8},'{8'h64,4'd8},'{8'h65,4'd8},
        '{8'h68,4'd8},'{8'h67,4'd8},'{8'hCC,4'd9},'{8'hCD,4'd9},
        '{8'hD2,4'd9},'{8'hD3,4'd9},'{8'hD4,4'd9},'{8'hD5,4'd9},
        '{8'hD6,4'd9},'{8'hD7,4'd9},'{8'hD8,4'd9},'{8'hD9,4'd9},
        '{8'hDA,4'd9},'{8'hDB,4'd9},'{8'h98,4'd9},'{8'h99,4'd9},
        '{8'h9A,4'd9},'{8'h18,4'd6},'{8'h9B,4'd9},
        '{8'h37,4'd10},'{8'h02,4'd3},'{8'h03,4'd2},'{8'h02,4'd2},
        '{8'h03,4'd3},'{8'h03,4'd4},'{8'h02,4'd4},'{8'h03,4'd5},
        '{8'h05,4'd6},'{8'h04,4'd6},'{8'h04,4'd7},'{8'h05,4'd7},
        '{8'h07,4'd7},'{8'h04,4'd8},'{8'h07,4'd8},'{8'h18,4'd9},
        '{8'h17,4'd10},'{8'h18,4'd10},'{8'h08,4'd10},'{8'h67,4'd11},
        '{8'h68,4'd11},'{8'h6C,4'd11},'{8'h37,4'd11},'{8'h28,4'd11},
        '{8'h17,4'd11},'{8'h18,4'd11},'{8'hCA,4'd12},'{8'hCB,4'd12},
        '{8'hCC,4'd12},'{8'hCD,4'd12},'{8'h68,4'd12},'{8'h69,4'd12},
        '{8'h6A,4'd12},'{8'h6B,4'd12},'{8'hD2,4'd12},'{8'hD3,4'd12},
        '{8'hD4,4'd12},'{8'hD5,4'd12},'{8'hD6,4'd12},'{8'hD7,4'd12},
        '{8'h6C,4'd12},'{8'h6D,4'd12},'{8'hDA,4'd12},'{8'hDB,4'd12},
        '{8'h54,4'd12},'{8'h55,4'd12},'{8'h56,4'd12},'{8'h57,4'd12},
        '{8'h64,4'd12},'{8'h65,4'd12},'{8'h52,4'd12},'{8'h53,4'd12},
        '{8'h24,4'd12},'{8'h37,4'd12},'{8'h38,4'd12},'{8'h27,4'd12},
        '{8'h28,4'd12},'{8'h58,4'd12},'{8'h59,4'd12},'{8'h2B,4'd12},
        '{8'h2C,4'd12},'{8'h5A,4'd12},'{8'h66,4'd12},'{8'h67,4'd12},
        '{8'h0F,4'd10},'{8'hC8,4'd12},'{8'hC9,4'd12},'{8'h5B,4'd12},
        '{8'h33,4'd12},'{8'h34,4'd12},'{8'h35,4'd12},'{8'h6C,4'd13},
        '{8'h6D,4'd13},'{8'h4A,4'd13},'{8'h4B,4'd13},'{8'h4C,4'd13},
        '{8'h4D,4'd13},'{8'h72,4'd13},'{8'h73,4'd13},'{8'h74,4'd13},
        '{8'h75,4'd13},'{8'h76,4'd13},'{8'h77,4'd13},'{8'h52,4'd13},
        '{8'h53,4'd13},'{8'h54,4'd13},'{8'h55,4'd13},'{8'h5A,4'd13},
        '{8'h5B,4'd13},'{8'h64,4'd13},'{8'h65,4'd13},
        '{8'h08,4'd11},'{8'h0C,4'd11},'{8'h0D,4'd11},'{8'h12,4'd12},
        '{8'h13,4'd12},'{8'h14,4'd12},'{8'h15,4'd12},'{8'h16,4'd12},
        '{8'h17,4'd12},'{8'h1C,4'd12},'{8'h1D,4'd12},'{8'h1E,4'd12},
        '{8'h1F,4'd12},
        '{8'h01,4'd4},'{8'h01,4'd3},'{8'h01,4'd1},'{8'h03,4'd3},
        '{8'h03,4'd6},'{8'h03,4'd7},'{8'h02,4'd3},'{8'h02,4'd6},
        '{8'h02,4'd7}
    };

    // true when the top len bits of a left-aligned window equal the code
    function automatic logic code_match(logic [WINDOW_BITS-1:0] win, cw_t e);
        logic [WINDOW_BITS-1:0] top;
        top = win >> (LEN_W'(WINDOW_BITS) - e.len);
        return top == WINDOW_BITS'(e.bits);
    endfunction

    // run that a combined run index stands for
    function automatic logic [RUN_W-1:0] run_of_index(logic [RUN_IDX_W-1:0] idx);
        logic [RUN_IDX_W-1:0] k;
        k = idx - RUN_IDX_W'(TERM_COUNT - 1);
        if (idx < RUN_IDX_W'(TERM_COUNT))
            return RUN_W'(idx);
        return RUN_W'(k) << 6;
    endfunction

    // table address of a run index; shared make-up codes follow both colours
    function automatic logic [ADDR_W-1:0] run_addr(logic black, logic [RUN_IDX_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = (black || (idx >= RUN_IDX_W'(COLOUR_COUNT))) ?
               ADDR_W'(COLOUR_COUNT) : ADDR_W'(WHITE_BASE);
        return ADDR_W'(idx) + base;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fax_rlc_index.sv
// ----------------------------------------------------------------------------
// Fax run-length code index logic
// Matches a decode window or maps an encode request onto a code table address.
// ----------------------------------------------------------------------------
`default_nettype none

module fax_rlc_index (
    input  wire logic [2:0]                            cmd,
    input  wire logic [fax_rlc_pkg::WINDOW_BITS-1:0]   code_window,
    input  wire logic [fax_rlc_pkg::RUN_LEN_W-1:0]     run_length,
    input  wire logic [fax_rlc_pkg::MODE_W-1:0]        mode_in,
    output fax_rlc_pkg::lookup_req_t                   req
);

    logic                                  black;
    logic                                  dec_hit;
    logic [fax_rlc_pkg::RUN_IDX_W-1:0]     dec_idx;
    logic                                  mode_hit;
    logic [fax_rlc_pkg::MODE_W-1:0]        mode_idx;
    logic [fax_rlc_pkg::RUN_IDX_W-1:0]     enc_idx;
    logic [fax_rlc_pkg::RUN_LEN_W-7:0]     enc_k;
    logic [fax_rlc_pkg::WINDOW_BITS-1:0]   mode_win;

    assign black = (cmd == fax_rlc_pkg::CMD_DEC_BLACK) || (cmd == fax_rlc_pkg::CMD_ENC_BLACK);

    // match the window against every run code of the chosen colour and the shared make-up codes
    // (codes are prefix-free, so the matching indexes can be ORed)
    always_comb
    begin
        logic hit_w;
        logic hit_b;
        dec_hit = 1'b0;
        dec_idx = '0;
        for (int i = 0; i < fax_rlc_pkg::COLOUR_COUNT; i++)
        begin
            hit_w = fax_rlc_pkg::code_match(code_window,
                        fax_rlc_pkg::CODE_TABLE[fax_rlc_pkg::WHITE_BASE + i]);
            hit_b = fax_rlc_pkg::code_match(code_window,
                        fax_rlc_pkg::CODE_TABLE[fax_rlc_pkg::BLACK_BASE + i]);
            if (black ? hit_b : hit_w)
            begin
                dec_hit = 1'b1;
                dec_idx = dec_idx | fax_rlc_pkg::RUN_IDX_W'(i);
            end
        end
        for (int j = 0; j < fax_rlc_pkg::SHARED_COUNT; j++)
        begin
            if (fax_rlc_pkg::code_match(code_window,
                    fax_rlc_pkg::CODE_TABLE[fax_rlc_pkg::SHARED_BASE + j]))
            begin
                dec_hit = 1'b1;
                dec_idx = dec_idx | fax_rlc_pkg::RUN_IDX_W'(fax_rlc_pkg::COLOUR_COUNT + j);
            end
        end
    end

    // match the low window bits against the mode codes, first hit wins
    assign mode_win = {code_window[fax_rlc_pkg::MODE_BITS-1:0],
                       (fax_rlc_pkg::WINDOW_BITS - fax_rlc_pkg::MODE_BITS)'(0)};

    always_comb
    begin
        mode_hit = 1'b0;
        mode_idx = '0;
        for (int m = 0; m < fax_rlc_pkg::MODE_COUNT; m++)
        begin
            if (!mode_hit && fax_rlc_pkg::code_match(mode_win,
                    fax_rlc_pkg::CODE_TABLE[fax_rlc_pkg::MODE_BASE + m]))
            begin
                mode_hit = 1'b1;
                mode_idx = fax_rlc_pkg::MODE_W'(m);
            end
        end
    end

    // pick the largest table run not above the length; clamp at 2560
    assign enc_k = run_length[fax_rlc_pkg::RUN_LEN_W-1:6];

    always_comb
    begin
        if (run_length < fax_rlc_pkg::RUN_LEN_W'(fax_rlc_pkg::TERM_COUNT))
            enc_idx = run_length[fax_rlc_pkg::RUN_IDX_W-1:0];
        else if (enc_k > (fax_rlc_pkg::RUN_LEN_W-6)'(fax_rlc_pkg::MAKEUP_COUNT))
            enc_idx = fax_rlc_pkg::RUN_IDX_W'(fax_rlc_pkg::TERM_COUNT - 1
                                              + fax_rlc_pkg::MAKEUP_COUNT);
        else
            enc_idx = fax_rlc_pkg::RUN_IDX_W'(fax_rlc_pkg::TERM_COUNT - 1)
                    + enc_k[fax_rlc_pkg::RUN_IDX_W-1:0];
    end

    // assemble the table request for the command
    always_comb
    begin
        req = '0;
        unique case (cmd)
            fax_rlc_pkg::CMD_DEC_WHITE,
            fax_rlc_pkg::CMD_DEC_BLACK:
            begin
                if (dec_hit)
                begin
                    req.hit       = 1'b1;
                    req.addr      = fax_rlc_pkg::run_addr(black, dec_idx);
                    req.run_value = fax_rlc_pkg::run_of_index(dec_idx);
                    req.is_makeup = dec_idx >= fax_rlc_pkg::RUN_IDX_W'(fax_rlc_pkg::TERM_COUNT);
                end
            end
            fax_rlc_pkg::CMD_DEC_MODE:
            begin
                if (mode_hit)
                begin
                    req.hit  = 1'b1;
                    req.addr = fax_rlc_pkg::ADDR_W'(fax_rlc_pkg::MODE_BASE)
                             + fax_rlc_pkg::ADDR_W'(mode_idx);
                    req.mode = mode_idx;
                end
            end
            fax_rlc_pkg::CMD_ENC_WHITE,
            fax_rlc_pkg::CMD_ENC_BLACK:
            begin
                req.hit       = 1'b1;
                req.addr      = fax_rlc_pkg::run_addr(black, enc_idx);
                req.run_value = fax_rlc_pkg::run_of_index(enc_idx);
                req.is_makeup = enc_idx >= fax_rlc_pkg::RUN_IDX_W'(fax_rlc_pkg::TERM_COUNT);
            end
            fax_rlc_pkg::CMD_ENC_MODE:
            begin
                if (mode_in < fax_rlc_pkg::MODE_W'(fax_rlc_pkg::MODE_COUNT))
                begin
                    req.hit  = 1'b1;
                    req.addr = fax_rlc_pkg::ADDR_W'(fax_rlc_pkg::MODE_BASE)
                             + fax_rlc_pkg::ADDR_W'(mode_in);
                    req.mode = mode_in;
                end
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/fax_rlc_rom.sv
// ----------------------------------------------------------------------------
// Fax run-length code ROM
// Synchronous code table with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fax_rlc_rom (
    input  wire logic                             clk,
    input  wire logic                             rd_en,
    input  wire logic [fax_rlc_pkg::ADDR_W-1:0]   rd_addr,
    output fax_rlc_pkg::cw_t                      rd_data
);

    localparam fax_rlc_pkg::cw_t ROM_MEM [fax_rlc_pkg::ROM_DEPTH] = fax_rlc_pkg::CODE_TABLE;

    fax_rlc_pkg::cw_t rd_data_reg;

    // read the entry on each accepted word
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= ROM_MEM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fax_run_length_code_lookup.sv
// ----------------------------------------------------------------------------
// Fax run-length code lookup
// T.4/T.6 Modified Huffman run and 2-D mode code decode and encode.
// ----------------------------------------------------------------------------
// A word is taken on every clock edge at which start is high; busy never
// rises, so one lookup can be issued each cycle. The result appears on the
// output ports in the cycle after the word is taken, marked by done for exactly
// one cycle; the receiver cannot stall it and must take it in that cycle. The
// result comes from the registered read of the code table ROM, whose
// address is formed in the same cycle the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fax_run_length_code_lookup_assert.svh"

module fax_run_length_code_lookup (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic [2:0]                            cmd,
    input  wire logic [fax_rlc_pkg::WINDOW_BITS-1:0]   code_window,
    input  wire logic [fax_rlc_pkg::RUN_LEN_W-1:0]     run_length,
    input  wire logic [fax_rlc_pkg::MODE_W-1:0]        mode_in,
    output      logic                                  done,
    output      logic                                  valid_res,
    output      logic [fax_rlc_pkg::WINDOW_BITS-1:0]   code_bits,
    output      logic [fax_rlc_pkg::LEN_W-1:0]         code_length,
    output      logic [fax_rlc_pkg::RUN_W-1:0]         run_value,
    output      logic                                  is_makeup,
    output      logic [fax_rlc_pkg::MODE_W-1:0]        mode_out
);

    fax_rlc_pkg::lookup_req_t  req;
    fax_rlc_pkg::cw_t          rom_data;
    logic                      accept;

    logic                      done_reg;
    logic                      done_next;
    logic                      hit_reg;
    logic [fax_rlc_pkg::RUN_W-1:0]  run_reg;
    logic                      makeup_reg;
    logic [fax_rlc_pkg::MODE_W-1:0] mode_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // form the table address and side fields
    fax_rlc_index u_index (
        .cmd         (cmd),
        .code_window (code_window),
        .run_length  (run_length),
        .mode_in     (mode_in),
        .req         (req)
    );

    // read the code word
    fax_rlc_rom u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (req.addr),
        .rd_data (rom_data)
    );

    // advance the result strobe
    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    // hold the side fields alongside the ROM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg    <= req.hit;
            run_reg    <= req.run_value;
            makeup_reg <= req.is_makeup;
            mode_reg   <= req.mode;
        end
    end

    // drop the code word when nothing matched
    assign done        = done_reg;
    assign valid_res   = hit_reg;
    assign code_bits   = hit_reg ? fax_rlc_pkg::WINDOW_BITS'(rom_data.bits) : '0;
    assign code_length = hit_reg ? rom_data.len : '0;
    assign run_value   = run_reg;
    assign is_makeup   = makeup_reg;
    assign mode_out    = mode_reg;

    `FAX_ASSERT_NXT(a_accept_gives_result, clk, rst_n, accept, done)
    `FAX_ASSERT_NXT(a_no_result_unasked, clk, rst_n, !accept, !done)
    `FAX_ASSERT_IMP(a_miss_is_empty, clk, rst_n, done && !valid_res, code_length == 0 && run_value == 0 && !is_makeup && mode_out == 0)
    `FAX_ASSERT_IMP(a_hit_has_length, clk, rst_n, done && valid_res, code_length != 0)
    `FAX_ASSERT_IMP(a_makeup_run_multiple, clk, rst_n, done && is_makeup, run_value[5:0] == 0 && run_value != 0)

endmodule

`default_nettype wire
